[design/ftt_pkg.sv]
// Shared types, constants and hash helpers for the flow table with ageing.
`default_nettype none
package ftt_pkg;

  localparam int FTT_BUCKETS = 1024;
  localparam int FTT_WAYS    = 4;
  localparam int TS_W        = 52;
  localparam int TTL_W       = 29;
  localparam int ADDR_W      = 64;
  localparam int PORT_W      = 16;
  localparam int PROTO_W     = 8;
  localparam int KIND_W      = 9;
  localparam int TOTAL_W     = 32;
  localparam int HASH_STEPS  = 6;

  localparam logic [TTL_W-1:0] TTL_RESET = 29'd1000000;

  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_HIT      = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXP_Q,
    S_EXP_S,
    S_EXP_T,
    S_HASH_INIT,
    S_HASH,
    S_FIN1,
    S_FIN2,
    S_PR_RD,
    S_PR_CMP,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [TS_W-1:0]    stamp;
    logic [31:0]        port_pair;
    logic [ADDR_W-1:0]  src_high;
    logic [ADDR_W-1:0]  src_low;
    logic [ADDR_W-1:0]  dst_high;
    logic [ADDR_W-1:0]  dst_low;
  } slot_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic exp_read_slot;
    logic exp_remove;
    logic hash_init;
    logic hash_step;
    logic fin1;
    logic fin2;
    logic probe_check;
    logic decide;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic live_zero;
    logic expire_due;
    logic eligible;
    logic hash_last;
    logic way_hit;
    logic way_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] addr_word(input logic v6, input logic [63:0] hi,
                                            input logic [63:0] lo);
    if (!v6) begin
      return swap32(lo[31:0]);
    end
    return swap32(hi[63:32]) + swap32(hi[31:0]) + swap32(lo[63:32]) + swap32(lo[31:0]);
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    return t ^ (t >> 6);
  endfunction

  function automatic logic [7:0] side_byte(input logic [31:0] a, input logic [15:0] p,
                                           input logic [2:0] step);
    logic [7:0] b;
    case (step)
      3'd0:    b = a[7:0];
      3'd1:    b = a[15:8];
      3'd2:    b = a[23:16];
      3'd3:    b = a[31:24];
      3'd4:    b = p[15:8];
      default: b = p[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[design/ftt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/ftt_ctrl.sv]
// Controller state machine: sequences clearing, expiry, hashing, probing and insertion.
`default_nettype none
module ftt_ctrl
  import ftt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_EXP_Q;
      S_EXP_Q:     state_next = stat.live_zero ? S_HASH_INIT : S_EXP_S;
      S_EXP_S:     state_next = S_EXP_T;
      S_EXP_T:     state_next = stat.expire_due ? S_EXP_Q : S_HASH_INIT;
      S_HASH_INIT: state_next = stat.eligible ? S_HASH : S_DONE;
      S_HASH:      if (stat.hash_last) state_next = S_FIN1;
      S_FIN1:      state_next = S_FIN2;
      S_FIN2:      state_next = S_PR_RD;
      S_PR_RD:     state_next = S_PR_CMP;
      S_PR_CMP: begin
        if (stat.way_hit) begin
          state_next = S_DONE;
        end else if (stat.way_last) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_PR_RD;
        end
      end
      S_DECIDE:    state_next = S_DONE;
      S_DONE:      if (stat.out_free) state_next = S_IDLE;
      default:     state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd   = '0;
    ready = 1'b0;
    unique case (state)
      S_CLEAR:     cmd.clear_step = 1'b1;
      S_IDLE: begin
        ready       = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXP_Q:     cmd = '0;
      S_EXP_S:     cmd.exp_read_slot = 1'b1;
      S_EXP_T:     cmd.exp_remove = stat.expire_due;
      S_HASH_INIT: cmd.hash_init = stat.eligible;
      S_HASH:      cmd.hash_step = 1'b1;
      S_FIN1:      cmd.fin1 = 1'b1;
      S_FIN2:      cmd.fin2 = 1'b1;
      S_PR_RD:     cmd = '0;
      S_PR_CMP:    cmd.probe_check = 1'b1;
      S_DECIDE:    cmd.decide = 1'b1;
      S_DONE:      cmd.load_out = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/ftt_dp.sv]
// Datapath: slot and age queue memories, hash unit, counters and output register.
`default_nettype none
module ftt_dp
  import ftt_pkg::*;
#(
  parameter int BUCKETS = FTT_BUCKETS,
  parameter int WAYS    = FTT_WAYS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dp_cmd_t                             cmd,
  output dp_stat_t                                 stat,
  input  wire logic [TTL_W-1:0]                    ttl,
  input  wire logic [TS_W-1:0]                     timestamp_us,
  input  wire logic [1:0]                          l3_type,
  input  wire logic [PROTO_W-1:0]                  protocol,
  input  wire logic [ADDR_W-1:0]                   src_addr_high,
  input  wire logic [ADDR_W-1:0]                   src_addr_low,
  input  wire logic [ADDR_W-1:0]                   dst_addr_high,
  input  wire logic [ADDR_W-1:0]                   dst_addr_low,
  input  wire logic [PORT_W-1:0]                   src_port,
  input  wire logic [PORT_W-1:0]                   dst_port,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [1:0]                               status,
  output logic [$clog2(BUCKETS)-1:0]               bucket_index,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        expired_count,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        live_entries,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        peak_entries,
  output logic [TOTAL_W-1:0]                       insert_total
);

  localparam int SLOTS = BUCKETS * WAYS;
  localparam int SW    = $clog2(SLOTS);
  localparam int BW    = $clog2(BUCKETS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_BITS = $bits(slot_t);

  logic [SW-1:0] clr_addr, head, tail, exp_slot;
  logic [CW-1:0] live, peak, expired;
  logic [TOTAL_W-1:0] ins_total;

  logic [TS_W-1:0]   cap_ts;
  logic              cap_eligible, cap_v6;
  logic [KIND_W-1:0] cap_kind;
  logic [ADDR_W-1:0] cap_sh, cap_sl, cap_dh, cap_dl;
  logic [PORT_W-1:0] cap_sp, cap_dp;

  logic [31:0] a_src, a_dst, hs, hd, h;
  logic [2:0]  step;
  logic [BW-1:0] bucket;
  logic [WW-1:0] way, free_way;
  logic          free_found;
  status_t       res_status;

  logic [SW-1:0] probe_addr, free_addr;
  logic [SW-1:0] s_raddr, s_waddr;
  logic          s_we;
  slot_t         s_wdata, s_rdata, new_slot;
  logic [SLOT_BITS-1:0] s_rbits;
  logic [SW-1:0] q_rdata;
  logic          q_we;
  logic [31:0]   fin1_t, fin2_a, fin2_b;
  logic [CW-1:0] live_inc;
  logic          fwd_match, rev_match;

  function automatic logic [SW-1:0] next_pos(input logic [SW-1:0] p);
    return (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign probe_addr = SW'(bucket) * SW'(WAYS) + SW'(way);
  assign free_addr  = SW'(bucket) * SW'(WAYS) + SW'(free_way);
  assign s_rdata    = slot_t'(s_rbits);

  assign new_slot = '{valid: 1'b1, kind: cap_kind, stamp: cap_ts,
                      port_pair: {cap_sp, cap_dp}, src_high: cap_sh, src_low: cap_sl,
                      dst_high: cap_dh, dst_low: cap_dl};

  always_comb begin
    s_raddr = cmd.exp_read_slot ? q_rdata : probe_addr;
    s_we    = cmd.clear_step || cmd.exp_remove || (cmd.decide && free_found);
    if (cmd.clear_step) begin
      s_waddr = clr_addr;
      s_wdata = '0;
    end else if (cmd.exp_remove) begin
      s_waddr = exp_slot;
      s_wdata = '0;
    end else begin
      s_waddr = free_addr;
      s_wdata = new_slot;
    end
  end

  assign q_we = cmd.decide && free_found;

  ftt_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rbits)
  );

  ftt_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_age_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail),
    .wdata (free_addr),
    .raddr (head),
    .rdata (q_rdata)
  );

  assign fwd_match = (s_rdata.src_high == cap_sh) && (s_rdata.src_low == cap_sl) &&
                     (s_rdata.dst_high == cap_dh) && (s_rdata.dst_low == cap_dl) &&
                     (s_rdata.port_pair == {cap_sp, cap_dp});
  assign rev_match = (s_rdata.src_high == cap_dh) && (s_rdata.src_low == cap_dl) &&
                     (s_rdata.dst_high == cap_sh) && (s_rdata.dst_low == cap_sl) &&
                     (s_rdata.port_pair == {cap_dp, cap_sp});

  assign fin1_t = (hs + hd) + ((hs + hd) << 3);
  assign fin2_a = h ^ (h >> 11);
  assign fin2_b = fin2_a + (fin2_a << 15);
  assign live_inc = live + 1'b1;

  always_comb begin
    stat.clear_last = (clr_addr == SW'(SLOTS - 1));
    stat.live_zero  = (live == '0);
    stat.expire_due = ({1'b0, s_rdata.stamp} + (TS_W + 1)'(ttl)) <= {1'b0, cap_ts};
    stat.eligible   = cap_eligible;
    stat.hash_last  = (step == 3'(HASH_STEPS - 1));
    stat.way_hit    = s_rdata.valid && (s_rdata.kind == cap_kind) && (fwd_match || rev_match);
    stat.way_last   = (way == WW'(WAYS - 1));
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      live      <= '0;
      peak      <= '0;
      ins_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= next_pos(clr_addr);
      end
      if (cmd.exp_remove) begin
        head <= next_pos(head);
        live <= live - 1'b1;
      end
      if (cmd.decide && free_found) begin
        tail <= next_pos(tail);
        live <= live_inc;
        if (peak < live_inc) begin
          peak <= live_inc;
        end
        if (ins_total != '1) begin
          ins_total <= ins_total + 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_ts       <= timestamp_us;
      cap_v6       <= (l3_type == L3_IPV6);
      cap_eligible <= ((l3_type == L3_IPV4) || (l3_type == L3_IPV6)) &&
                      ((protocol == PROTO_TCP) || (protocol == PROTO_UDP));
      cap_kind     <= {(l3_type == L3_IPV6), protocol};
      cap_sh       <= (l3_type == L3_IPV6) ? src_addr_high : '0;
      cap_dh       <= (l3_type == L3_IPV6) ? dst_addr_high : '0;
      cap_sl       <= (l3_type == L3_IPV6) ? src_addr_low : {32'd0, src_addr_low[31:0]};
      cap_dl       <= (l3_type == L3_IPV6) ? dst_addr_low : {32'd0, dst_addr_low[31:0]};
      cap_sp       <= src_port;
      cap_dp       <= dst_port;
      expired      <= '0;
      bucket       <= '0;
      res_status   <= ST_IGNORED;
    end
    if (cmd.exp_read_slot) begin
      exp_slot <= q_rdata;
    end
    if (cmd.exp_remove) begin
      expired <= expired + 1'b1;
    end
    if (cmd.hash_init) begin
      a_src      <= addr_word(cap_v6, cap_sh, cap_sl);
      a_dst      <= addr_word(cap_v6, cap_dh, cap_dl);
      hs         <= '0;
      hd         <= '0;
      step       <= '0;
      way        <= '0;
      free_way   <= '0;
      free_found <= 1'b0;
    end
    if (cmd.hash_step) begin
      hs   <= mix(hs, side_byte(a_src, cap_sp, step));
      hd   <= mix(hd, side_byte(a_dst, cap_dp, step));
      step <= step + 1'b1;
    end
    if (cmd.fin1) begin
      h <= fin1_t;
    end
    if (cmd.fin2) begin
      bucket <= fin2_b[BW-1:0];
    end
    if (cmd.probe_check) begin
      if (!s_rdata.valid && !free_found) begin
        free_found <= 1'b1;
        free_way   <= way;
      end
      if (stat.way_hit) begin
        res_status <= ST_HIT;
      end
      way <= way + 1'b1;
    end
    if (cmd.decide) begin
      res_status <= free_found ? ST_INSERTED : ST_FULL;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      bucket_index  <= bucket;
      expired_count <= expired;
      live_entries  <= live;
      peak_entries  <= peak;
      insert_total  <= ins_total;
    end
  end

endmodule
`default_nettype wire

[design/flow_table_with_ttl_aging.sv]
// Top level of the flow table with TTL ageing: lifetime register, controller and datapath.
// Each item is handled in turn: expiry of due flows, then hashing, then probing of the
// bucket's ways and insertion; an ignored item skips hashing and probing.
// No new item is taken before the last one is through; the next item is taken while the
// result waits. Reset: synchronous; a clearing pass over all BUCKETS*WAYS slots follows,
// with no item taken. The lifetime register returns to 1000000 us at reset.
`default_nettype none
module flow_table_with_ttl_aging
  import ftt_pkg::*;
#(
  parameter int BUCKETS = FTT_BUCKETS,
  parameter int WAYS    = FTT_WAYS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [TTL_W-1:0]                    cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [TS_W-1:0]                     timestamp_us,
  input  wire logic [1:0]                          l3_type,
  input  wire logic [PROTO_W-1:0]                  protocol,
  input  wire logic [ADDR_W-1:0]                   src_addr_high,
  input  wire logic [ADDR_W-1:0]                   src_addr_low,
  input  wire logic [ADDR_W-1:0]                   dst_addr_high,
  input  wire logic [ADDR_W-1:0]                   dst_addr_low,
  input  wire logic [PORT_W-1:0]                   src_port,
  input  wire logic [PORT_W-1:0]                   dst_port,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               status,
  output logic [$clog2(BUCKETS)-1:0]               bucket_index,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        expired_count,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        live_entries,
  output logic [$clog2(BUCKETS*WAYS+1)-1:0]        peak_entries,
  output logic [TOTAL_W-1:0]                       insert_total
);

  logic [TTL_W-1:0] ttl;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (cfg_we) begin
      ttl <= cfg_wdata;
    end
  end

  assign in_stall = !ready;

  ftt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .ready    (ready)
  );

  ftt_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .ttl           (ttl),
    .timestamp_us  (timestamp_us),
    .l3_type       (l3_type),
    .protocol      (protocol),
    .src_addr_high (src_addr_high),
    .src_addr_low  (src_addr_low),
    .dst_addr_high (dst_addr_high),
    .dst_addr_low  (dst_addr_low),
    .src_port      (src_port),
    .dst_port      (dst_port),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .bucket_index  (bucket_index),
    .expired_count (expired_count),
    .live_entries  (live_entries),
    .peak_entries  (peak_entries),
    .insert_total  (insert_total)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while a previous item was still in work");

  a_live_le_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (live_entries <= peak_entries))
    else $error("live flow count above peak");

  a_ignored_bucket: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_IGNORED) |-> (bucket_index == '0))
    else $error("ignored item reports a bucket");

  a_insert_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_INSERTED) |-> (live_entries != '0))
    else $error("insertion reported with no live flows");

endmodule
`default_nettype wire

[tb/flow_table_with_ttl_aging_test.sv]
// Self-checking testbench for the flow table with TTL ageing: predictor, stimulus and result checks.
`default_nettype none
module flow_table_with_ttl_aging_test;
  import ftt_pkg::*;

  localparam int NSLOT = FTT_BUCKETS * FTT_WAYS;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic [TS_W-1:0]    ts;
    logic [1:0]         l3;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  sh;
    logic [ADDR_W-1:0]  sl;
    logic [ADDR_W-1:0]  dh;
    logic [ADDR_W-1:0]  dl;
    logic [PORT_W-1:0]  sp;
    logic [PORT_W-1:0]  dp;
  } pkt_t;

  typedef struct packed {
    logic [1:0]          st;
    logic [9:0]          bkt;
    logic [12:0]         expired;
    logic [12:0]         live;
    logic [12:0]         peak;
    logic [TOTAL_W-1:0]  inserts;
  } verdict_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [TTL_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [TS_W-1:0] timestamp_us = '0;
  logic [1:0] l3_type = '0;
  logic [PROTO_W-1:0] protocol = '0;
  logic [ADDR_W-1:0] src_addr_high = '0, src_addr_low = '0;
  logic [ADDR_W-1:0] dst_addr_high = '0, dst_addr_low = '0;
  logic [PORT_W-1:0] src_port = '0, dst_port = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [9:0] bucket_index;
  logic [12:0] expired_count, live_entries, peak_entries;
  logic [TOTAL_W-1:0] insert_total;

  flow_table_with_ttl_aging dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .timestamp_us(timestamp_us), .l3_type(l3_type), .protocol(protocol),
    .src_addr_high(src_addr_high), .src_addr_low(src_addr_low),
    .dst_addr_high(dst_addr_high), .dst_addr_low(dst_addr_low),
    .src_port(src_port), .dst_port(dst_port),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .bucket_index(bucket_index), .expired_count(expired_count),
    .live_entries(live_entries), .peak_entries(peak_entries),
    .insert_total(insert_total)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // flow table mirror
  logic [ADDR_W-1:0] f_sh[NSLOT], f_sl[NSLOT], f_dh[NSLOT], f_dl[NSLOT];
  logic [31:0] f_pp[NSLOT];
  logic [KIND_W-1:0] f_kind[NSLOT];
  logic f_valid[NSLOT];
  logic [TS_W-1:0] f_time[NSLOT];
  int unsigned age_fifo[$];
  int unsigned n_live, n_peak;
  logic [31:0] n_ins;
  logic [TTL_W-1:0] ttl;

  verdict_t pending[$];
  bit failed = 0;
  int tx_idle = 8, rx_idle = 55;
  bit rx_hold = 0;
  int quiet = 0;
  logic [TS_W-1:0] now_us = 0;
  pkt_t pool[$];

  function automatic logic [31:0] bswap(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [31:0] stir(logic [31:0] h, logic [7:0] b);
    h = h + b;
    h = h + (h << 10);
    return h ^ (h >> 6);
  endfunction

  function automatic logic [31:0] side_sum(logic v6, logic [63:0] hi, logic [63:0] lo,
                                           logic [15:0] port);
    logic [31:0] a, h;
    a = v6 ? bswap(hi[63:32]) + bswap(hi[31:0]) + bswap(lo[63:32]) + bswap(lo[31:0])
           : bswap(lo[31:0]);
    h = 0;
    h = stir(h, a[7:0]);
    h = stir(h, a[15:8]);
    h = stir(h, a[23:16]);
    h = stir(h, a[31:24]);
    h = stir(h, port[15:8]);
    h = stir(h, port[7:0]);
    return h;
  endfunction

  function automatic verdict_t predict_lookup(pkt_t p);
    verdict_t v;
    int unsigned expd, s, fw;
    logic v6, hit;
    logic [63:0] am, hm;
    logic [KIND_W-1:0] k;
    logic [31:0] h;
    expd = 0; fw = FTT_WAYS; hit = 0;
    v = '0;
    while (n_live > 0) begin
      s = age_fifo[0];
      if ({12'd0, f_time[s]} + 64'(ttl) > {12'd0, p.ts}) break;
      f_valid[s] = 0;
      void'(age_fifo.pop_front());
      n_live--;
      expd++;
    end
    if ((p.l3 == L3_IPV4 || p.l3 == L3_IPV6) &&
        (p.proto == PROTO_TCP || p.proto == PROTO_UDP)) begin
      v6 = p.l3 == L3_IPV6;
      am = v6 ? '1 : 64'hffff_ffff;
      hm = v6 ? '1 : '0;
      k = {v6, p.proto};
      h = side_sum(v6, p.sh, p.sl, p.sp) + side_sum(v6, p.dh, p.dl, p.dp);
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      v.bkt = h[9:0];
      for (int w = 0; w < FTT_WAYS && !hit; w++) begin
        s = v.bkt * FTT_WAYS + w;
        if (!f_valid[s]) begin
          if (fw == FTT_WAYS) fw = w;
        end else if (f_kind[s] == k) begin
          if ((((f_sh[s] ^ p.sh) & hm) == 0) && (((f_sl[s] ^ p.sl) & am) == 0) &&
              (((f_dh[s] ^ p.dh) & hm) == 0) && (((f_dl[s] ^ p.dl) & am) == 0) &&
              f_pp[s] == {p.sp, p.dp}) hit = 1;
          if ((((f_sh[s] ^ p.dh) & hm) == 0) && (((f_sl[s] ^ p.dl) & am) == 0) &&
              (((f_dh[s] ^ p.sh) & hm) == 0) && (((f_dl[s] ^ p.sl) & am) == 0) &&
              f_pp[s] == {p.dp, p.sp}) hit = 1;
        end
      end
      if (hit) v.st = ST_HIT;
      else if (fw == FTT_WAYS) v.st = ST_FULL;
      else begin
        s = v.bkt * FTT_WAYS + fw;
        f_sh[s] = p.sh & hm; f_sl[s] = p.sl & am;
        f_dh[s] = p.dh & hm; f_dl[s] = p.dl & am;
        f_pp[s] = {p.sp, p.dp}; f_kind[s] = k; f_time[s] = p.ts; f_valid[s] = 1;
        age_fifo.push_back(s);
        n_live++;
        if (n_peak < n_live) n_peak = n_live;
        if (n_ins != 32'hffff_ffff) n_ins++;
        v.st = ST_INSERTED;
      end
    end
    v.expired = 13'(expd);
    v.live = 13'(n_live);
    v.peak = 13'(n_peak);
    v.inserts = n_ins;
    return v;
  endfunction

  task automatic send_packet(pkt_t p);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    timestamp_us <= p.ts; l3_type <= p.l3; protocol <= p.proto;
    src_addr_high <= p.sh; src_addr_low <= p.sl;
    dst_addr_high <= p.dh; dst_addr_low <= p.dl;
    src_port <= p.sp; dst_port <= p.dp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(predict_lookup(p));
  endtask

  task automatic drain_and_wait();
    in_valid <= 0;
    while (pending.size() > 0) @(posedge clk);
    repeat (11 + 2 * FTT_WAYS + 3 * NSLOT) @(posedge clk);
  endtask

  task automatic write_ttl(logic [TTL_W-1:0] val);
    cfg_we <= 1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    ttl = val;
  endtask

  function automatic pkt_t random_flow();
    pkt_t p;
    p.ts = now_us;
    p.l3 = 2'($urandom_range(1, 2));
    p.proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    p.sh = {$urandom, $urandom}; p.sl = {$urandom, $urandom};
    p.dh = {$urandom, $urandom}; p.dl = {$urandom, $urandom};
    p.sp = 16'($urandom); p.dp = 16'($urandom);
    return p;
  endfunction

  function automatic pkt_t swap_dir(pkt_t p);
    pkt_t q;
    q = p;
    q.sh = p.dh; q.sl = p.dl; q.dh = p.sh; q.dl = p.sl; q.sp = p.dp; q.dp = p.sp;
    return q;
  endfunction

  task automatic test_directed();
    pkt_t p, q;
    p = random_flow();
    p.ts = 0;
    send_packet(p);
    send_packet(p);
    send_packet(swap_dir(p));
    q = p; q.l3 = 2'd0; send_packet(q);
    q = p; q.l3 = 2'd3; send_packet(q);
    q = p; q.proto = 8'd1; send_packet(q);
    q = p; q.proto = 8'd255; send_packet(q);
    q = random_flow(); q.ts = 0; q.l3 = L3_IPV4; q.sh = '1; q.dh = '1;
    q.sl = '1; q.dl = '0; q.sp = '1; q.dp = '0; send_packet(q);
    q.sh = '0; q.dh = '0; q.sl[63:32] = '0; send_packet(q);
    q = random_flow(); q.ts = 0; q.l3 = L3_IPV6; q.sh = '1; q.sl = '1;
    q.dh = '1; q.dl = '1; q.sp = '1; q.dp = '1; send_packet(q);
    q = p; q.ts = 999999; send_packet(q);
    q = p; q.ts = 1000000; send_packet(q);
    q = p; q.ts = 5; send_packet(q);
    q = p; q.ts = 3000000; q.proto = 8'd7; send_packet(q);
    // six IPv6 flows reusing the ports and swapped source halves of p, destination varied
    for (int i = 0; i < 6; i++) begin
      q = p; q.ts = 3000000; q.sp = p.sp; q.dp = p.dp;
      q.l3 = L3_IPV6; q.sh = p.sl; q.sl = p.sh;
      q.dh = {32'd0, 32'(i)}; q.dl = {32'(i), 32'd0};
      send_packet(q);
    end
    now_us = 3000000;
  endtask

  task automatic test_bucket_full();
    pkt_t p, q;
    // IPv6 chunk sums are symmetric: shuffling chunks keeps the bucket
    p = random_flow();
    p.l3 = L3_IPV6; p.ts = now_us;
    for (int i = 0; i < 6; i++) begin
      q = p;
      case (i % 3)
        0: q.sh = {p.sh[31:0], p.sh[63:32]};
        1: q.sl = {p.sl[31:0], p.sl[63:32]};
        default: q.sh = {p.sl[63:32], p.sh[31:0]};
      endcase
      if (i >= 3) begin
        q.dh = {q.dh[31:0], q.dh[63:32]};
      end
      if (i == 5) q.sl = {p.sh[63:32], p.sl[31:0]};
      send_packet(q);
    end
    send_packet(p);
  endtask

  task automatic test_random(int count);
    pkt_t p;
    int r;
    for (int i = 0; i < count; i++) begin
      now_us = now_us + $urandom_range(200000);
      r = $urandom_range(99);
      if (r < 35 || pool.size() == 0) begin
        p = random_flow();
        if (pool.size() < 64) pool.push_back(p);
        else pool[$urandom_range(63)] = p;
      end else if (r < 80) begin
        p = pool[$urandom_range(pool.size() - 1)];
        p.ts = now_us;
        if ($urandom_range(1)) p = swap_dir(p);
      end else begin
        p = random_flow();
        p.l3 = 2'($urandom_range(3));
        p.proto = 8'($urandom);
        if ($urandom_range(9) == 0) p.ts = now_us - $urandom_range(1000);
      end
      send_packet(p);
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1;
    test_random(20);
    rx_hold = 0;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (rx_hold) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < rx_idle);
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        hold = 0;
        while (rx_hold && hold < 400) begin
          @(posedge clk);
          hold++;
        end
        rx_hold = 0;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, status);
        failed = 1;
      end else begin
        e = pending.pop_front();
        if (status !== e.st || bucket_index !== e.bkt || expired_count !== e.expired ||
            live_entries !== e.live || peak_entries !== e.peak ||
            insert_total !== e.inserts) begin
          $display("%0t: mismatch expected st=%0d bkt=%0d exp=%0d live=%0d peak=%0d ins=%0d",
                   $time, e.st, e.bkt, e.expired, e.live, e.peak, e.inserts);
          $display("%0t:          actual st=%0d bkt=%0d exp=%0d live=%0d peak=%0d ins=%0d",
                   $time, status, bucket_index, expired_count, live_entries,
                   peak_entries, insert_total);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT + 3 * NSLOT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) f_valid[i] = 0;
    n_live = 0; n_peak = 0; n_ins = 0; ttl = TTL_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;
    test_directed();
    test_bucket_full();
    test_backpressure();
    test_random(150);
    drain_and_wait();
    write_ttl('1);
    tx_idle = 55; rx_idle = 8;
    test_random(120);
    drain_and_wait();
    write_ttl('0);
    test_random(40);
    drain_and_wait();
    write_ttl(29'd300000);
    tx_idle = 0; rx_idle = 0;
    test_random(150);
    drain_and_wait();
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
